/* design/ttcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ttcc_pkg;

   localparam int TAB_WIDTH   = 8;
   localparam int MAX_COLUMNS = 255;
   localparam int MAX_ROWS    = 127;

   localparam logic [7:0] COLUMNS_RESET     = 8'd80;
   localparam logic [6:0] ROWS_RESET        = 7'd25;
   localparam logic       PIXEL_ORDER_RESET = 1'b1;

   localparam logic [7:0] CH_BELL  = 8'd7;
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;

   localparam logic [7:0] LEVEL = 8'd192;

   typedef enum logic [1:0] {
      REG_COLUMNS     = 2'd0,
      REG_ROWS        = 2'd1,
      REG_PIXEL_ORDER = 2'd2
   } reg_index_type;

   typedef enum logic [0:0] {
      OP_DRAW   = 1'b0,
      OP_SCROLL = 1'b1
   } op_type;

   typedef struct packed {
      logic [7:0] columns;
      logic [6:0] rows;
      logic       pixel_order;
   } cfg_type;

   typedef struct packed {
      logic [2:0] bg_index;
      logic [2:0] fg_index;
      logic       printable;
      logic [7:0] char_code;
   } item_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  glyph;
      logic [7:0]  cell_col;
      logic [6:0]  cell_row;
      logic [23:0] fore_color;
      logic [23:0] back_color;
      logic        last;
      logic [7:0]  cursor_col_after;
      logic [6:0]  cursor_row_after;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef logic [8:0] tab_table_type [256];

   // next tab stop for every column, built without division
   function automatic tab_table_type make_tab_table(input int tw);
      tab_table_type tbl;
      int stop;
      stop = tw;
      for (int i = 0; i < 256; i++) begin
         if (i >= stop) begin
            stop = stop + tw;
         end
         tbl[i] = 9'(stop);
      end
      return tbl;
   endfunction

   function automatic logic [23:0] pack_color(input logic [2:0] idx, input logic order);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = idx[0] ? LEVEL : 8'd0;
      g = idx[1] ? LEVEL : 8'd0;
      b = idx[2] ? LEVEL : 8'd0;
      return order ? {r, g, b} : {b, g, r};
   endfunction

endpackage

`default_nettype wire

/* design/ttcc_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module ttcc_step #(
   parameter int TAB_WIDTH   = ttcc_pkg::TAB_WIDTH,
   parameter int MAX_COLUMNS = ttcc_pkg::MAX_COLUMNS,
   parameter int MAX_ROWS    = ttcc_pkg::MAX_ROWS
) (
   input  wire                  clock,
   input  wire                  reset,
   input  ttcc_pkg::cfg_type    cfg,
   input  wire                  item_valid,
   input  ttcc_pkg::item_type   item,
   input  wire  [1:0]           space,
   output logic                 consume,
   output ttcc_pkg::push_type   push
);

   localparam logic [7:0] MaxCols = 8'(MAX_COLUMNS);
   localparam logic [6:0] MaxRows = 7'(MAX_ROWS);
   localparam ttcc_pkg::tab_table_type TabStop = ttcc_pkg::make_tab_table(TAB_WIDTH);

   logic [7:0] col_ff, col_in;
   logic [6:0] row_ff, row_in;

   logic [7:0]  cols_eff;
   logic [6:0]  rows_eff;
   logic [6:0]  bottom;
   logic        down_scroll;
   logic [6:0]  down_row;
   logic [8:0]  tab_next;
   logic        draw;
   logic        scroll;
   logic [1:0]  n_results;
   logic [23:0] fg;
   logic [23:0] bg;
   ttcc_pkg::result_type draw_res;
   ttcc_pkg::result_type scroll_res;

   always_comb begin
      if (cfg.columns == 8'd0) begin
         cols_eff = 8'd1;
      end else if (cfg.columns > MaxCols) begin
         cols_eff = MaxCols;
      end else begin
         cols_eff = cfg.columns;
      end
      if (cfg.rows == 7'd0) begin
         rows_eff = 7'd1;
      end else if (cfg.rows > MaxRows) begin
         rows_eff = MaxRows;
      end else begin
         rows_eff = cfg.rows;
      end
   end

   assign bottom      = rows_eff - 7'd1;
   assign down_scroll = row_ff >= bottom;
   assign down_row    = down_scroll ? bottom : row_ff + 7'd1;
   assign tab_next    = TabStop[col_ff];

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      draw   = 1'b0;
      scroll = 1'b0;
      case (item.char_code)
         ttcc_pkg::CH_BELL: begin
         end
         ttcc_pkg::CH_BS: begin
            if (col_ff != 8'd0) begin
               col_in = col_ff - 8'd1;
            end else if (row_ff != 7'd0) begin
               col_in = cols_eff - 8'd1;
               row_in = row_ff - 7'd1;
            end
         end
         ttcc_pkg::CH_LF: begin
            col_in = 8'd0;
            row_in = down_row;
            scroll = down_scroll;
         end
         ttcc_pkg::CH_CR: begin
            col_in = 8'd0;
         end
         ttcc_pkg::CH_TAB: begin
            if (tab_next >= {1'b0, cols_eff}) begin
               col_in = 8'd0;
               row_in = down_row;
               scroll = down_scroll;
            end else begin
               col_in = tab_next[7:0];
            end
         end
         default: begin
            if (item.printable) begin
               draw = 1'b1;
               if ({1'b0, col_ff} + 9'd1 >= {1'b0, cols_eff}) begin
                  col_in = 8'd0;
                  row_in = down_row;
                  scroll = down_scroll;
               end else begin
                  col_in = col_ff + 8'd1;
               end
            end
         end
      endcase
   end

   assign fg        = ttcc_pkg::pack_color(item.fg_index, cfg.pixel_order);
   assign bg        = ttcc_pkg::pack_color(item.bg_index, cfg.pixel_order);
   assign n_results = {1'b0, draw} + {1'b0, scroll};
   assign consume   = item_valid && (n_results <= space);

   always_comb begin
      draw_res.op               = ttcc_pkg::OP_DRAW;
      draw_res.glyph            = item.char_code;
      draw_res.cell_col         = col_ff;
      draw_res.cell_row         = row_ff;
      draw_res.fore_color       = fg;
      draw_res.back_color       = bg;
      draw_res.last             = !scroll;
      draw_res.cursor_col_after = col_in;
      draw_res.cursor_row_after = row_in;

      scroll_res.op               = ttcc_pkg::OP_SCROLL;
      scroll_res.glyph            = ttcc_pkg::CH_SPACE;
      scroll_res.cell_col         = 8'd0;
      scroll_res.cell_row         = bottom;
      scroll_res.fore_color       = fg;
      scroll_res.back_color       = bg;
      scroll_res.last             = 1'b1;
      scroll_res.cursor_col_after = col_in;
      scroll_res.cursor_row_after = row_in;

      push.count  = n_results;
      push.first  = draw ? draw_res : scroll_res;
      push.second = scroll_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 8'd0;
         row_ff <= 7'd0;
      end else if (consume) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

/* design/ttcc_rsp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module ttcc_rsp_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push_en,
   input  ttcc_pkg::push_type    push,
   input  wire                   pop_ready,
   output logic                  head_valid,
   output ttcc_pkg::result_type  head,
   output logic [1:0]            space
);

   ttcc_pkg::result_type slot0_ff, slot0_in;
   ttcc_pkg::result_type slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;

   logic       pop;
   logic [1:0] keep_n;
   logic [1:0] n_push;
   ttcc_pkg::result_type keep0;

   assign head_valid = count_ff != 2'd0;
   assign head       = slot0_ff;
   assign space      = 2'd2 - count_ff;
   assign pop        = head_valid && pop_ready;

   always_comb begin
      keep0    = pop ? slot1_ff : slot0_ff;
      keep_n   = count_ff - {1'b0, pop};
      n_push   = push_en ? push.count : 2'd0;
      count_in = keep_n + n_push;
      if (keep_n == 2'd0) begin
         slot0_in = push.first;
         slot1_in = push.second;
      end else if (keep_n == 2'd1) begin
         slot0_in = keep0;
         slot1_in = push.first;
      end else begin
         slot0_in = slot0_ff;
         slot1_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

/* design/text_console_cursor_controller_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  req_tdata, req_tuser
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata, rsp_tuser, rsp_tlast
// csr       in         csr_we                 csr_index, csr_wdata
//
// input register then two-entry output queue; one request per cycle at one command each
// while rsp_tready holds; a request giving a draw and a scroll waits for an empty queue
// and fills both entries, so the next request waits until rsp takes a command
// an accepted request passes the input register and then a queue entry before rsp_tvalid
// synchronous reset clears cursor, queue and registers to their reset values
// a stalled rsp side holds at most two commands before req_tready drops

module text_console_cursor_controller_unit #(
   parameter int TAB_WIDTH   = ttcc_pkg::TAB_WIDTH,
   parameter int MAX_COLUMNS = ttcc_pkg::MAX_COLUMNS,
   parameter int MAX_ROWS    = ttcc_pkg::MAX_ROWS
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [15:0]  req_tdata,   // char_code, fg_index, bg_index, zero pad
   input  wire          req_tuser,   // printable
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [87:0]  rsp_tdata,   // glyph, cell_col, cell_row, fore_color, back_color,
                                     // cursor_col_after, cursor_row_after, zero pad
   output logic         rsp_tuser,   // op
   output logic         rsp_tlast,
   input  wire          csr_we,
   input  wire  [1:0]   csr_index,
   input  wire  [7:0]   csr_wdata
);

   ttcc_pkg::cfg_type    cfg_ff;
   logic                 in_valid_ff;
   ttcc_pkg::item_type   in_item_ff;
   ttcc_pkg::item_type   req_item;
   logic                 consume;
   ttcc_pkg::push_type   push;
   logic [1:0]           space;
   ttcc_pkg::result_type head;

   assign req_item.char_code = req_tdata[7:0];
   assign req_item.printable = req_tuser;
   assign req_item.fg_index  = req_tdata[10:8];
   assign req_item.bg_index  = req_tdata[13:11];

   assign req_tready = !in_valid_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.columns     <= ttcc_pkg::COLUMNS_RESET;
         cfg_ff.rows        <= ttcc_pkg::ROWS_RESET;
         cfg_ff.pixel_order <= ttcc_pkg::PIXEL_ORDER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ttcc_pkg::REG_COLUMNS:     cfg_ff.columns     <= csr_wdata;
            ttcc_pkg::REG_ROWS:        cfg_ff.rows        <= csr_wdata[6:0];
            ttcc_pkg::REG_PIXEL_ORDER: cfg_ff.pixel_order <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_item;
      end
   end

   ttcc_step #(
      .TAB_WIDTH   (TAB_WIDTH),
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (in_valid_ff),
      .item       (in_item_ff),
      .space      (space),
      .consume    (consume),
      .push       (push)
   );

   ttcc_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (consume),
      .push       (push),
      .pop_ready  (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .space      (space)
   );

   assign rsp_tdata = {2'b00, head.cursor_row_after, head.cursor_col_after,
                       head.back_color, head.fore_color, head.cell_row,
                       head.cell_col, head.glyph};
   assign rsp_tuser = head.op;
   assign rsp_tlast = head.last;

endmodule

`default_nettype wire
